/* rtl/irs_pkg.sv */
// Package for the interval remap splitter: mode and status codes, request struct.
// No dependencies; used by every module of the block.
`default_nettype none
package irs_pkg;
  localparam int AW = 40;

  typedef enum logic [1:0] {
    MODE_CLEAR     = 2'd0,
    MODE_INSERT    = 2'd1,
    MODE_TRANSLATE = 2'd2,
    MODE_NONE      = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_PIECE    = 3'd0,
    ST_STORED   = 3'd1,
    ST_CLEARED  = 3'd2,
    ST_FULL     = 3'd3,
    ST_REJECTED = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

  // Classified request passed from front to back.
  typedef struct packed {
    mode_t        mode;
    logic         bad;     // insert: empty or overflowing segment
    logic [AW-1:0] tgt;
    logic [AW-1:0] src;
    logic [AW-1:0] seg_end;
    logic [AW-1:0] lo;
    logic [AW-1:0] hi;
  } req_t;
endpackage
`default_nettype wire

/* rtl/irs_front.sv */
// Front end: accepts requests, drops unknown modes, checks segment overflow,
// and queues classified requests. Depends on irs_pkg.
`default_nettype none
module irs_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [1:0]        mode,
  input  wire logic [irs_pkg::AW-1:0] target_start,
  input  wire logic [irs_pkg::AW-1:0] source_start,
  input  wire logic [irs_pkg::AW-1:0] span_length,
  input  wire logic [irs_pkg::AW-1:0] range_low,
  input  wire logic [irs_pkg::AW-1:0] range_high,
  output logic                   q_valid,
  output irs_pkg::req_t          q_req,
  input  wire logic              q_take
);
  import irs_pkg::*;

  // two-entry queue
  req_t        mem [2];
  logic        wptr, rptr;
  logic [1:0]  cnt;
  req_t        req_in;
  logic [AW:0] src_sum, tgt_sum;
  logic        acc, keep;

  assign full    = (cnt == 2'd2);
  assign acc     = push && !full;
  assign keep    = acc && (mode != MODE_NONE);
  assign q_valid = (cnt != 2'd0);
  assign q_req   = mem[rptr];

  // overflow check on the segment ends; an end at the top address is allowed
  always_comb begin
    src_sum = {1'b0, source_start} + {1'b0, span_length};
    tgt_sum = {1'b0, target_start} + {1'b0, span_length};
    req_in.mode    = mode_t'(mode);
    req_in.bad     = (span_length == '0) || src_sum[AW] || tgt_sum[AW];
    req_in.tgt     = target_start;
    req_in.src     = source_start;
    req_in.seg_end = src_sum[AW-1:0];
    req_in.lo      = range_low;
    req_in.hi      = range_high;
  end

  always_ff @(posedge clk) begin
    if (keep) mem[wptr] <= req_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (keep) wptr <= ~wptr;
      if (q_take) rptr <= ~rptr;
      cnt <= cnt + {1'b0, keep} - {1'b0, q_take};
    end
  end
endmodule
`default_nettype wire

/* rtl/irs_back.sv */
// Back end: segment table, insert with shift, translate walk, result queue.
// Depends on irs_pkg; fed by irs_front.
`default_nettype none
module irs_back #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  irs_pkg::req_t          q_req,
  output logic                   q_take,
  output logic                   empty,
  input  wire logic              pop,
  output logic [irs_pkg::AW-1:0] piece_low,
  output logic [irs_pkg::AW-1:0] piece_high,
  output logic [2:0]             status,
  output logic                   last
);
  import irs_pkg::*;
  localparam int IW = $clog2(TABLE_ENTRIES + 1);
  localparam int XW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_SHIFT = 6'b000100,
    S_WALK  = 6'b001000,
    S_MAP   = 6'b010000,
    S_TAIL  = 6'b100000
  } state_t;

  // segment table held in registers, each entry read at the walk index
  logic [AW-1:0] seg_source [TABLE_ENTRIES];
  logic [AW-1:0] seg_end    [TABLE_ENTRIES];
  logic [AW-1:0] seg_target [TABLE_ENTRIES];
  logic [IW-1:0] seg_count;

  state_t        state;
  req_t          cur;
  logic [IW-1:0] idx;
  logic [IW-1:0] pos;
  logic          hit;
  logic          ins_ok;   // insert written into the table
  logic [AW-1:0] lo;
  logic [AW-1:0] s_r, t_r, b_r;

  // output register; valid while load and pop toggles differ
  logic          o_valid;
  logic          o_put, o_got;
  logic [AW-1:0] o_lo, o_hi;
  logic [2:0]    o_st;
  logic          o_last;
  logic          o_free;

  logic [AW-1:0] s_i, e_i;
  logic [XW-1:0] ix;
  assign ix  = idx[XW-1:0];
  assign s_i = seg_source[ix];
  assign e_i = seg_end[ix];

  assign o_valid    = o_put ^ o_got;
  assign o_free     = !o_valid || pop;
  assign empty      = !o_valid;
  assign piece_low  = o_lo;
  assign piece_high = o_hi;
  assign status     = o_st;
  assign last       = o_last;
  assign q_take     = (state == S_IDLE) && q_valid;

  // result taken by the consumer
  always_ff @(posedge clk) begin
    if (rst) begin
      o_got <= 1'b0;
    end else if (pop && o_valid) begin
      o_got <= ~o_got;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      seg_count <= '0;
      o_put     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur    <= q_req;
            idx    <= '0;
            pos    <= '0;
            hit    <= 1'b0;
            ins_ok <= 1'b0;
            lo     <= q_req.lo;
            unique case (q_req.mode)
              MODE_CLEAR: begin
                seg_count <= '0;
                state     <= S_TAIL;
              end
              MODE_INSERT:    state <= S_CHECK;
              MODE_TRANSLATE: state <= S_WALK;
              default:        state <= S_IDLE;
            endcase
          end
        end
        // overlap scan and sorted place search, one entry per cycle
        S_CHECK: begin
          if (idx == seg_count || cur.bad) begin
            if (cur.bad || hit || seg_count == IW'(TABLE_ENTRIES)) begin
              state <= S_TAIL;
            end else begin
              idx   <= seg_count;
              state <= S_SHIFT;
            end
          end else begin
            if (cur.src < e_i && s_i < cur.seg_end) hit <= 1'b1;
            if (s_i < cur.src) pos <= idx + IW'(1);
            idx <= idx + IW'(1);
          end
        end
        // move entries up one place, then write the new one
        S_SHIFT: begin
          if (idx == pos) begin
            seg_source[ix] <= cur.src;
            seg_end[ix]    <= cur.seg_end;
            seg_target[ix] <= cur.tgt;
            seg_count      <= seg_count + IW'(1);
            ins_ok         <= 1'b1;
            state          <= S_TAIL;
          end else begin
            seg_source[ix] <= seg_source[XW'(idx - IW'(1))];
            seg_end[ix]    <= seg_end[XW'(idx - IW'(1))];
            seg_target[ix] <= seg_target[XW'(idx - IW'(1))];
            idx            <= idx - IW'(1);
          end
        end
        // walk: gap piece before a covering segment, then the mapped piece
        S_WALK: begin
          if (cur.lo >= cur.hi || lo >= cur.hi || idx == seg_count) begin
            state <= S_TAIL;
          end else if (e_i <= lo || s_i >= cur.hi) begin
            idx <= idx + IW'(1);
          end else if (o_free) begin
            s_r <= s_i;
            t_r <= seg_target[ix];
            b_r <= (cur.hi < e_i) ? cur.hi : e_i;
            if (lo < s_i) begin
              o_put  <= ~o_put;
              o_lo   <= lo;
              o_hi   <= s_i;
              o_st   <= ST_PIECE;
              o_last <= 1'b0;
              lo     <= s_i;
            end
            state <= S_MAP;
          end
        end
        S_MAP: begin
          if (o_free) begin
            o_put   <= ~o_put;
            o_lo    <= t_r + (lo - s_r);
            o_hi    <= t_r + (b_r - s_r);
            o_st    <= ST_PIECE;
            o_last  <= (b_r >= cur.hi) || (idx + IW'(1) == seg_count && b_r >= cur.hi);
            lo      <= b_r;
            idx     <= idx + IW'(1);
            state   <= (b_r >= cur.hi) ? S_IDLE : S_WALK;
          end
        end
        // final single result
        S_TAIL: begin
          if (o_free) begin
            o_put   <= ~o_put;
            o_lo    <= '0;
            o_hi    <= '0;
            o_last  <= 1'b1;
            state   <= S_IDLE;
            unique case (cur.mode)
              MODE_CLEAR:  o_st <= ST_CLEARED;
              MODE_INSERT: o_st <= (cur.bad || hit) ? ST_REJECTED :
                                   ins_ok ? ST_STORED : ST_FULL;
              default: begin
                if (cur.lo >= cur.hi) begin
                  o_st <= ST_EMPTY;
                end else begin
                  o_st <= ST_PIECE;
                  o_lo <= lo;
                  o_hi <= cur.hi;
                end
              end
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/interval_remap_splitter_core.sv */
// Top level of the interval remap splitter: front queue plus table back end.
// Depends on irs_pkg, irs_front and irs_back.
`default_nettype none
// Requests enter a two-deep queue and are worked one at a time by the back
// end. Clear is accepted and then gives its result. Insert is accepted, scans
// every stored entry for overlap and decides; a stored segment then shifts
// each entry above its place up one and is written, and the result follows;
// an empty or overflowing segment is rejected without a scan. Translate is
// accepted, walks the stored segments, maps each one that covers part of the
// range and emits an uncovered tail if one is left (up to 2*seg_count+1
// pieces), the single table walk index setting the pace.
// The result register lets a piece wait while the walk continues up to the
// next output; a result not popped stalls the back end.
module interval_remap_splitter_core #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] mode,
  input  wire logic [39:0] target_start,
  input  wire logic [39:0] source_start,
  input  wire logic [39:0] span_length,
  input  wire logic [39:0] range_low,
  input  wire logic [39:0] range_high,
  output logic            empty,
  input  wire logic       pop,
  output logic [39:0]     piece_low,
  output logic [39:0]     piece_high,
  output logic [2:0]      status,
  output logic            last
);
  import irs_pkg::*;

  logic q_valid, q_take;
  req_t q_req;

  irs_front u_front (
    .clk, .rst, .push, .full, .mode, .target_start, .source_start,
    .span_length, .range_low, .range_high,
    .q_valid, .q_req, .q_take
  );

  irs_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk, .rst, .q_valid, .q_req, .q_take,
    .empty, .pop, .piece_low, .piece_high, .status, .last
  );

`ifndef SYNTH
  // a non-piece status always ends its request
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_PIECE) |-> last)
    else $error("non-piece result without last");
  // a waiting result holds while not popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(piece_low) && $stable(status)))
    else $error("result changed while waiting");
  // status codes stay in range
  a_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (status <= ST_EMPTY))
    else $error("bad status code");
`endif
endmodule
`default_nettype wire
